// File: rtl/core/twcp_pkg.sv
package twcp_pkg;

    localparam int TEX_SIZE_DEF   = 64;
    localparam int TILE_COUNT_DEF = 9;
    localparam int SCREEN_MAX_DEF = 4096;

    localparam logic [31:0] YSIDE_MASK = 32'd8355711;

    localparam int CFG_W  = 13;
    localparam int CFG_IW = 2;

    localparam logic [CFG_IW-1:0] CFG_SCREEN_HEIGHT = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_SCREEN_WIDTH  = 2'd1;

    localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd480;
    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd640;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_SETUP = 2'd1,
        KIND_ROW   = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

endpackage

// File: rtl/core/textured_wall_column_pixel.sv
// Textured wall column pixel engine. Texture writes (kind 0) fill a single-port
// texture memory of two sets of TILE_COUNT tiles; a column setup (kind 1) latches
// the column parameters and takes effect for the very next beat; each row beat
// (kind 2) produces one framebuffer address and colour. One beat is accepted every
// cycle while the output is not stalled. A row beat passes through one entry stage,
// a pipelined restoring divider of one quotient bit per stage for the texture row,
// then the registered texture memory read port, to the output. Texture writes
// travel the same pipeline and reach the memory in order with row reads.
module textured_wall_column_pixel
    import twcp_pkg::*;
#(
    parameter int TEX_SIZE   = TEX_SIZE_DEF,
    parameter int TILE_COUNT = TILE_COUNT_DEF,
    parameter int SCREEN_MAX = SCREEN_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_kind,
    input  logic              i_tex_set,
    input  logic [7:0]        i_tile_code,
    input  logic [11:0]       i_texel_index,
    input  logic [31:0]       i_texel_color,
    input  logic [11:0]       i_column,
    input  logic [15:0]       i_line_height,
    input  logic [15:0]       i_wall_frac,
    input  logic              i_side,
    input  logic              i_ray_x_positive,
    input  logic              i_ray_y_negative,
    input  logic [11:0]       i_row,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [23:0]       o_pixel_address,
    output logic [31:0]       o_pixel_color
);

    localparam int TEXW  = $clog2(TEX_SIZE);
    localparam int DEPTH = 2 * TILE_COUNT * TEX_SIZE * TEX_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int TLW   = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
    localparam int RW    = 26 + TEXW;
    localparam int NS    = TEXW + 2;
    localparam logic [TEXW-1:0] TX_MAX = TEXW'(TEX_SIZE - 1);

    function automatic logic [CFG_W-1:0] sat_screen(input logic [CFG_W-1:0] v);
        if (32'(v) > 32'(SCREEN_MAX)) begin
            return CFG_W'(SCREEN_MAX);
        end
        return v;
    endfunction

    logic [CFG_W-1:0] r_sh, r_sw;
    logic [11:0]      r_cx;
    logic [TEXW-1:0]  r_tx;
    logic [TLW-1:0]   r_tile;
    logic             r_set, r_cside;
    logic [15:0]      r_h;

    logic [TEXW-1:0] n_tx, w_tx_raw;
    logic [TLW-1:0]  n_tile;
    logic [8:0]      w_code_m1;

    logic adv, acc;
    assign o_stall = o_valid && i_stall;
    assign adv     = !o_stall;
    assign acc     = i_valid && adv;

    // Configuration and column state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh    <= sat_screen(SCREEN_HEIGHT_RST);
            r_sw    <= sat_screen(SCREEN_WIDTH_RST);
            r_cx    <= '0;
            r_tx    <= '0;
            r_tile  <= '0;
            r_set   <= 1'b0;
            r_cside <= 1'b0;
            r_h     <= 16'd1;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SCREEN_HEIGHT) begin
                    r_sh <= sat_screen(i_cfg_data);
                end else if (i_cfg_idx == CFG_SCREEN_WIDTH) begin
                    r_sw <= sat_screen(i_cfg_data);
                end
            end
            if (acc && t_kind'(i_kind) == KIND_SETUP) begin
                r_cx    <= i_column;
                r_h     <= (i_line_height == 16'd0) ? 16'd1 : i_line_height;
                r_tx    <= n_tx;
                r_tile  <= n_tile;
                r_set   <= i_tex_set;
                r_cside <= i_side;
            end
        end
    end

    always_comb begin
        w_tx_raw = i_wall_frac[15 -: TEXW];
        if ((!i_side && i_ray_x_positive) || (i_side && i_ray_y_negative)) begin
            n_tx = TX_MAX - w_tx_raw;
        end else begin
            n_tx = w_tx_raw;
        end
        w_code_m1 = (i_tile_code == 8'd0) ? 9'd0 : 9'(i_tile_code) - 9'd1;
        if (32'(w_code_m1) > 32'(TILE_COUNT - 1)) begin
            n_tile = TLW'(TILE_COUNT - 1);
        end else begin
            n_tile = w_code_m1[TLW-1:0];
        end
    end

    // Entry stage values.
    logic [25:0]   w_d;
    logic          w_pos;
    logic [AW-1:0] w_wr_base, w_row_base, w_addr0;
    logic          w_wr_ok;
    logic [24:0]   w_pix;
    always_comb begin
        w_d   = 26'({i_row, 8'b0}) - 26'({r_sh, 7'b0}) + 26'({r_h, 7'b0});
        w_pos = !w_d[25] && (w_d != 26'd0);
        w_wr_base  = AW'((32'(i_tex_set) * 32'(TILE_COUNT) + 32'(i_tile_code))
                         << (2 * TEXW));
        w_row_base = AW'((32'(r_set) * 32'(TILE_COUNT) + 32'(r_tile)) << (2 * TEXW));
        w_wr_ok = (32'(i_tile_code) < 32'(TILE_COUNT))
                  && (32'(i_texel_index) < 32'(TEX_SIZE * TEX_SIZE));
        w_addr0 = (t_kind'(i_kind) == KIND_WRITE) ? w_wr_base + AW'(i_texel_index)
                                                  : w_row_base;
        w_pix = 25'(i_row) * 25'(r_sw) + 25'(r_cx);
    end

    logic            r_v    [NS];
    logic            r_wr   [NS];
    logic [AW-1:0]   r_addr [NS];
    logic [31:0]     r_wdat [NS];
    logic [RW-1:0]   r_rem  [NS];
    logic [TEXW:0]   r_q    [NS];
    logic [23:0]     r_den  [NS];
    logic [TEXW-1:0] r_ptx  [NS];
    logic            r_pside[NS];
    logic [23:0]     r_pix  [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (adv) begin
            r_v[0] <= acc && (t_kind'(i_kind) == KIND_ROW
                              || (t_kind'(i_kind) == KIND_WRITE && w_wr_ok));
            for (int s = 1; s < NS; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    // Payload of the pipeline: one quotient bit per stage, most significant first.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_wr[0]    <= (t_kind'(i_kind) == KIND_WRITE);
            r_addr[0]  <= w_addr0;
            r_wdat[0]  <= i_texel_color;
            r_rem[0]   <= w_pos ? (RW'(w_d[24:0]) << TEXW) : '0;
            r_q[0]     <= '0;
            r_den[0]   <= {r_h, 8'b0};
            r_ptx[0]   <= r_tx;
            r_pside[0] <= r_cside;
            r_pix[0]   <= w_pix[23:0];
            for (int s = 1; s < NS; s++) begin
                r_wr[s]    <= r_wr[s-1];
                r_addr[s]  <= r_addr[s-1];
                r_wdat[s]  <= r_wdat[s-1];
                r_den[s]   <= r_den[s-1];
                r_ptx[s]   <= r_ptx[s-1];
                r_pside[s] <= r_pside[s-1];
                r_pix[s]   <= r_pix[s-1];
                if (r_rem[s-1] >= (RW'(r_den[s-1]) << (NS - 1 - s))) begin
                    r_rem[s] <= r_rem[s-1] - (RW'(r_den[s-1]) << (NS - 1 - s));
                    r_q[s]   <= r_q[s-1] | ((TEXW+1)'(1) << (NS - 1 - s));
                end else begin
                    r_rem[s] <= r_rem[s-1];
                    r_q[s]   <= r_q[s-1];
                end
            end
        end
    end

    // Texture memory stage.
    logic [TEXW-1:0] w_ty;
    logic [AW-1:0]   w_maddr;
    logic [31:0]     mem [DEPTH];
    logic [31:0]     r_rdata;
    logic            r_oside;
    logic [23:0]     r_opix;
    logic            r_ov;

    always_comb begin
        // The top quotient bit means the row lies past the texture end.
        w_ty    = r_q[NS-1][TEXW] ? TX_MAX : r_q[NS-1][TEXW-1:0];
        w_maddr = r_wr[NS-1] ? r_addr[NS-1]
                             : r_addr[NS-1] + AW'({w_ty, r_ptx[NS-1]});
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_v[NS-1] && r_wr[NS-1]) begin
                mem[w_maddr] <= r_wdat[NS-1];
            end
            r_rdata <= mem[w_maddr];
            r_oside <= r_pside[NS-1];
            r_opix  <= r_pix[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_v[NS-1] && !r_wr[NS-1];
        end
    end

    assign o_valid         = r_ov;
    assign o_pixel_address = r_opix;
    assign o_pixel_color   = r_oside ? ((r_rdata >> 1) & YSIDE_MASK) : r_rdata;

endmodule

// File: bench/testbench.sv
module testbench;
    import twcp_pkg::*;

    localparam int TEXELS  = TEX_SIZE_DEF * TEX_SIZE_DEF;
    localparam int DEPTH   = 2 * TILE_COUNT_DEF * TEXELS;
    localparam int LIMIT   = 400000;
    localparam int SETTLE  = 24;

    typedef struct {
        t_kind       kind;
        logic        set;
        logic [7:0]  code;
        logic [11:0] tidx;
        logic [31:0] tcol;
        logic [11:0] col;
        logic [15:0] lh;
        logic [15:0] frac;
        logic        side;
        logic        xpos;
        logic        yneg;
        logic [11:0] row;
        logic        typed;
        logic [23:0] t_addr;
        logic [31:0] t_colour;
    } t_beat;

    typedef struct {
        logic [23:0] addr;
        logic [31:0] colour;
    } t_pixel;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [1:0]        i_kind;
    logic              i_tex_set;
    logic [7:0]        i_tile_code;
    logic [11:0]       i_texel_index;
    logic [31:0]       i_texel_color;
    logic [11:0]       i_column;
    logic [15:0]       i_line_height;
    logic [15:0]       i_wall_frac;
    logic              i_side;
    logic              i_ray_x_positive;
    logic              i_ray_y_negative;
    logic [11:0]       i_row;
    logic              i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              o_valid;
    logic              i_stall;
    logic [23:0]       o_pixel_address;
    logic [31:0]       o_pixel_color;

    textured_wall_column_pixel i_dut (.*);

    // Mirror of the block's state.
    logic [31:0] tex_mem [0:DEPTH-1];
    bit          tex_written [0:DEPTH-1];
    int unsigned scr_height;
    int unsigned scr_width;
    logic [11:0] cur_x;
    int unsigned cur_tex_x;
    int unsigned cur_tile;
    logic        cur_set;
    logic        cur_side;
    int unsigned cur_height;

    t_pixel pending_pixels[$];
    t_beat  directed[$];
    int     mismatches;
    int     cycles;
    int     sent;
    int     stall_left;
    bit     hold_req;
    bit     quiet;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int unsigned sat_screen(int unsigned v);
        return v > SCREEN_MAX_DEF ? SCREEN_MAX_DEF : v;
    endfunction

    function automatic int unsigned texture_row(logic [11:0] r);
        longint d;
        longint q;
        d = longint'(r) * 256 - longint'(scr_height) * 128 + longint'(cur_height) * 128;
        if (d <= 0)
            return 0;
        q = ((d * TEX_SIZE_DEF) / cur_height) >> 8;
        return q > TEX_SIZE_DEF - 1 ? TEX_SIZE_DEF - 1 : int'(q);
    endfunction

    function automatic int unsigned fetch_addr(logic [11:0] r);
        return (int'(cur_set) * TILE_COUNT_DEF + cur_tile) * TEXELS
               + texture_row(r) * TEX_SIZE_DEF + cur_tex_x;
    endfunction

    function automatic t_beat random_beat();
        t_beat b;
        b.kind  = t_kind'($urandom_range(0, 3));
        b.set   = 1'($urandom_range(0, 1));
        b.code  = 8'($urandom_range(0, 255));
        b.tidx  = 12'($urandom_range(0, 4095));
        b.tcol  = $urandom;
        b.col   = 12'($urandom_range(0, 4095));
        b.lh    = 16'($urandom_range(0, 65535));
        b.frac  = 16'($urandom_range(0, 65535));
        b.side  = 1'($urandom_range(0, 1));
        b.xpos  = 1'($urandom_range(0, 1));
        b.yneg  = 1'($urandom_range(0, 1));
        b.row   = 12'($urandom_range(0, 4095));
        b.typed = 1'b0;
        b.t_addr = '0;
        b.t_colour = '0;
        return b;
    endfunction

    function automatic t_beat mk_write(logic s, logic [7:0] c, logic [11:0] idx,
                                       logic [31:0] colour);
        t_beat b;
        b = random_beat();
        b.kind = KIND_WRITE;
        b.set = s;
        b.code = c;
        b.tidx = idx;
        b.tcol = colour;
        return b;
    endfunction

    function automatic t_beat mk_setup(logic s, logic [7:0] c, logic [11:0] x,
                                       logic [15:0] h, logic [15:0] f,
                                       logic sd, logic xp, logic yn);
        t_beat b;
        b = random_beat();
        b.kind = KIND_SETUP;
        b.set = s;
        b.code = c;
        b.col = x;
        b.lh = h;
        b.frac = f;
        b.side = sd;
        b.xpos = xp;
        b.yneg = yn;
        return b;
    endfunction

    function automatic t_beat mk_row(logic [11:0] r);
        t_beat b;
        b = random_beat();
        b.kind = KIND_ROW;
        b.row = r;
        return b;
    endfunction

    // Updates the mirrored state for one accepted beat and queues the pixel of a row beat.
    function automatic void absorb_beat(t_beat b);
        int unsigned a;
        int unsigned tx;
        t_pixel p;
        case (b.kind)
            KIND_WRITE: begin
                if (b.code < TILE_COUNT_DEF) begin
                    a = (int'(b.set) * TILE_COUNT_DEF + b.code) * TEXELS + b.tidx;
                    tex_mem[a] = b.tcol;
                    tex_written[a] = 1'b1;
                end
            end
            KIND_SETUP: begin
                tx = (int'(b.frac) * TEX_SIZE_DEF) >> 16;
                if ((!b.side && b.xpos) || (b.side && b.yneg))
                    tx = TEX_SIZE_DEF - 1 - tx;
                cur_tex_x = tx;
                cur_x = b.col;
                cur_height = b.lh == 0 ? 1 : b.lh;
                cur_tile = b.code == 0 ? 0 : b.code - 1;
                if (cur_tile > TILE_COUNT_DEF - 1)
                    cur_tile = TILE_COUNT_DEF - 1;
                cur_set = b.set;
                cur_side = b.side;
            end
            KIND_ROW: begin
                if (b.typed) begin
                    p.addr = b.t_addr;
                    p.colour = b.t_colour;
                end else begin
                    p.colour = tex_mem[fetch_addr(b.row)];
                    if (cur_side)
                        p.colour = (p.colour >> 1) & YSIDE_MASK;
                    p.addr = 24'(longint'(b.row) * scr_width + cur_x);
                end
                pending_pixels.push_back(p);
            end
            default: ;
        endcase
    endfunction

    task automatic offer_beat(t_beat b);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid          <= 1'b1;
        i_kind           <= b.kind;
        i_tex_set        <= b.set;
        i_tile_code      <= b.code;
        i_texel_index    <= b.tidx;
        i_texel_color    <= b.tcol;
        i_column         <= b.col;
        i_line_height    <= b.lh;
        i_wall_frac      <= b.frac;
        i_side           <= b.side;
        i_ray_x_positive <= b.xpos;
        i_ray_y_negative <= b.yneg;
        i_row            <= b.row;
        forever begin
            @(posedge i_clk);
            if (!o_stall)
                break;
        end
        absorb_beat(b);
        sent++;
    endtask

    // A row beat may only read a texel that has been written, so one is
    // written first where needed.
    task automatic send_beat(t_beat b);
        int unsigned a;
        if (b.kind == KIND_ROW) begin
            a = fetch_addr(b.row);
            if (!tex_written[a])
                offer_beat(mk_write(cur_set, 8'(cur_tile), 12'(a % TEXELS), $urandom));
        end
        offer_beat(b);
    endtask

    task automatic write_register(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending_pixels.size() == 0);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SCREEN_HEIGHT)
            scr_height = sat_screen(value);
        else
            scr_width = sat_screen(value);
    endtask

    task automatic random_traffic(int beats);
        int start;
        int n;
        int pick;
        t_beat b;
        start = sent;
        while (sent - start < beats) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                b = random_beat();
                b.kind = KIND_NONE;
                send_beat(b);
            end else if (pick < 20) begin
                b = random_beat();
                b.kind = KIND_WRITE;
                if ($urandom_range(0, 3) != 0)
                    b.code = 8'($urandom_range(0, TILE_COUNT_DEF - 1));
                send_beat(b);
            end else begin
                b = random_beat();
                b.kind = KIND_SETUP;
                b.code = 8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                      : $urandom_range(1, TILE_COUNT_DEF));
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    b.lh = 0;
                else if (pick > 3)
                    b.lh = 16'($urandom_range(1, 1200));
                send_beat(b);
                n = $urandom_range(1, 12);
                repeat (n) begin
                    b = mk_row(12'($urandom_range(0, 2) == 0 ? $urandom_range(0, 4095)
                                                             : $urandom_range(0, scr_height)));
                    send_beat(b);
                end
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_req) begin
            stall_left = 300;
            hold_req = 1'b0;
        end
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            stall_left = quiet ? 0 : $urandom_range(0, 4);
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel: address %h colour %h",
                             o_pixel_address, o_pixel_color);
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel_address !== want.addr || o_pixel_color !== want.colour) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: address %h (want %h), colour %h (want %h)",
                                 o_pixel_address, want.addr, o_pixel_color, want.colour);
                end
            end
        end
    end

    initial begin
        t_beat b;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_kind = KIND_NONE;
        i_tex_set = 1'b0;
        i_tile_code = '0;
        i_texel_index = '0;
        i_texel_color = '0;
        i_column = '0;
        i_line_height = '0;
        i_wall_frac = '0;
        i_side = 1'b0;
        i_ray_x_positive = 1'b0;
        i_ray_y_negative = 1'b0;
        i_row = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        mismatches = 0;
        cycles = 0;
        sent = 0;
        stall_left = 0;
        hold_req = 1'b0;
        quiet = 1'b0;
        scr_height = SCREEN_HEIGHT_RST;
        scr_width = SCREEN_WIDTH_RST;
        cur_x = '0;
        cur_tex_x = 0;
        cur_tile = 0;
        cur_set = 1'b0;
        cur_side = 1'b0;
        cur_height = 1;
        foreach (tex_written[k]) begin
            tex_written[k] = 1'b0;
            tex_mem[k] = '0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Straight after reset the column sits on texel 0 of tile 0, set 0.
        directed.push_back(mk_write(1'b0, 8'd0, 12'd0, 32'hFFFF_FFFF));
        b = mk_row(12'd0);
        b.typed = 1'b1;
        b.t_addr = 24'd0;
        b.t_colour = 32'hFFFF_FFFF;
        directed.push_back(b);
        directed.push_back(mk_write(1'b1, 8'd8, 12'd4095, 32'h0000_0000));
        directed.push_back(mk_write(1'b0, 8'd9, 12'd5, 32'h1234_5678));
        directed.push_back(mk_write(1'b1, 8'd255, 12'd4095, 32'hFFFF_FFFF));
        b = random_beat();
        b.kind = KIND_NONE;
        directed.push_back(b);
        directed.push_back(mk_setup(1'b0, 8'd0, 12'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0));
        directed.push_back(mk_row(12'd4095));
        directed.push_back(mk_setup(1'b1, 8'd255, 12'd4095, 16'd65535, 16'd65535,
                                    1'b1, 1'b0, 1'b0));
        directed.push_back(mk_row(12'd0));
        directed.push_back(mk_row(12'd4095));
        directed.push_back(mk_setup(1'b0, 8'd1, 12'd100, 16'd480, 16'd32768,
                                    1'b0, 1'b1, 1'b1));
        directed.push_back(mk_row(12'd0));
        directed.push_back(mk_row(12'd240));
        directed.push_back(mk_row(12'd479));
        directed.push_back(mk_setup(1'b1, 8'd9, 12'd2047, 16'd1, 16'd65535,
                                    1'b1, 1'b1, 1'b1));
        directed.push_back(mk_row(12'd240));
        directed.push_back(mk_row(12'd241));
        directed.push_back(mk_setup(1'b0, 8'd10, 12'd7, 16'd64, 16'd1,
                                    1'b0, 1'b0, 1'b1));
        directed.push_back(mk_row(12'd239));
        foreach (directed[k])
            send_beat(directed[k]);

        random_traffic(150);
        write_register(CFG_SCREEN_HEIGHT, 13'd1);
        write_register(CFG_SCREEN_WIDTH, 13'd1);
        quiet = 1'b1;
        random_traffic(150);
        quiet = 1'b0;
        write_register(CFG_SCREEN_HEIGHT, 13'd4096);
        write_register(CFG_SCREEN_WIDTH, 13'd4096);
        hold_req = 1'b1;
        random_traffic(200);
        // Values above the screen maximum saturate.
        write_register(CFG_SCREEN_HEIGHT, 13'd8191);
        write_register(CFG_SCREEN_WIDTH, 13'd8191);
        random_traffic(150);
        write_register(CFG_SCREEN_HEIGHT, 13'($urandom_range(1, 4096)));
        write_register(CFG_SCREEN_WIDTH, 13'($urandom_range(1, 4096)));
        random_traffic(200);
        write_register(CFG_SCREEN_HEIGHT, 13'd240);
        write_register(CFG_SCREEN_WIDTH, 13'd320);
        random_traffic(180);

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending_pixels.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
